// ===== hw/rtl/tsl_pkg.sv =====
`timescale 1ns / 1ps

package tsl_pkg;

  // Width of a slot number inside the cell chain; covers tables of up to 64 slots.
  localparam int SLOT_IDX_W = 6;
  localparam int ID_W       = 32;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_INVALID  = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    op_t              opcode;
    logic [ID_W-1:0]  object_id;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot_index;
  } rsp_t;

  // Search token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic                   valid;
    op_t                    opcode;
    logic [ID_W-1:0]        key;
    logic                   hit;
    logic [SLOT_IDX_W-1:0]  hit_idx;
    logic                   free;
    logic [SLOT_IDX_W-1:0]  free_idx;
  } token_t;

  // Write command broadcast to every cell when a transaction commits.
  typedef struct packed {
    logic                   clear_all;
    logic                   en;
    logic [SLOT_IDX_W-1:0]  idx;
    logic [ID_W-1:0]        data;
  } wr_cmd_t;

endpackage

// ===== hw/rtl/tsl_cell.sv =====
`timescale 1ns / 1ps

module tsl_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  tsl_pkg::token_t   tok_in,
  output tsl_pkg::token_t   tok_out,
  input  tsl_pkg::wr_cmd_t  wr
);

  localparam int IdxW = tsl_pkg::SLOT_IDX_W;
  localparam logic [IdxW-1:0] CELL_IDX = IdxW'(INDEX);

  logic [tsl_pkg::ID_W-1:0] id;
  tsl_pkg::token_t           tok_next;
  logic                      match;
  logic                      empty;

  assign match = (id == tok_in.key);
  assign empty = (id == '0);

  // The first matching and the first empty cell along the chain claim the token.
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = CELL_IDX;
    end
    if (!tok_in.free && empty) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = CELL_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id <= '0;
    end else if (wr.clear_all) begin
      id <= '0;
    end else if (wr.en && (wr.idx == CELL_IDX)) begin
      id <= wr.data;
    end
  end

endmodule

// ===== hw/rtl/texture_slot_table_core.sv =====
`timescale 1ns / 1ps

// Associative slot table built as a row of SLOT_COUNT cells, each holding one
// 32-bit object id (zero marks an empty slot); every slot is empty after reset.
// A request transaction launches a search token that moves through the row one
// cell per cycle, picking up the lowest slot holding the id and the lowest
// empty slot. When the token leaves the last cell the request commits: an
// acquire that hits returns that slot, one that misses writes the id into the
// lowest empty slot or reports the table full, a release empties the matching
// slot, a lookup changes nothing, and clear-all empties every slot at once.
// Id zero is answered as invalid, but for clear-all. Every request gives
// exactly one response. Requests are handled one at a time: an accepted
// request passes through the launch register, one register per cell of the
// row and the final register, whose commit also accepts the next request.
// The commit waits for as long as an earlier response sits unaccepted in the
// output register. The response sits in an output register, so a new
// request is accepted while the previous response still waits to be taken.

module texture_slot_table_core #(
  parameter int SLOT_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tsl_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tsl_pkg::rsp_t  rsp
);

  // Launch register feeding the first cell, then one token register per cell.
  tsl_pkg::token_t  in_tok;
  tsl_pkg::token_t  chain [SLOT_COUNT+1];
  tsl_pkg::token_t  fin;
  tsl_pkg::wr_cmd_t wr;
  tsl_pkg::rsp_t    rsp_next;

  logic busy;
  logic req_accept;
  logic commit;
  logic [SLOT_COUNT+1:0] live;

  assign req_accept = req_valid && req_ready;

  // The final token commits when the response register is free or being drained.
  assign commit    = fin.valid && (!rsp_valid || rsp_ready);
  // A new request may enter in the commit cycle; it reaches the first cell
  // only after the commit writes have landed.
  assign req_ready = !busy || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_accept) begin
      busy <= 1'b1;
    end else if (commit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tok.valid <= 1'b0;
    end else begin
      in_tok.valid    <= req_accept;
      if (req_accept) begin
        in_tok.opcode   <= req.opcode;
        in_tok.key      <= req.object_id;
        in_tok.hit      <= 1'b0;
        in_tok.hit_idx  <= '0;
        in_tok.free     <= 1'b0;
        in_tok.free_idx <= '0;
      end
    end
  end

  assign chain[0] = in_tok;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    tsl_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .wr      (wr)
    );
  end

  // The finished token waits here until the response register can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else if (chain[SLOT_COUNT].valid) begin
      fin <= chain[SLOT_COUNT];
    end else if (commit) begin
      fin.valid <= 1'b0;
    end
  end

  // Decide the outcome and the table write from the finished token.
  always_comb begin
    wr        = '0;
    wr.data   = fin.key;
    rsp_next  = '{status: tsl_pkg::ST_NOTFOUND, slot_index: 4'd0};
    if (fin.opcode == tsl_pkg::OP_CLEAR) begin
      rsp_next.status = tsl_pkg::ST_CLEARED;
      wr.clear_all    = commit;
    end else if (fin.key == '0) begin
      rsp_next.status = tsl_pkg::ST_INVALID;
    end else if (fin.hit) begin
      rsp_next.status     = tsl_pkg::ST_HIT;
      rsp_next.slot_index = fin.hit_idx[3:0];
      if (fin.opcode == tsl_pkg::OP_RELEASE) begin
        wr.en   = commit;
        wr.idx  = fin.hit_idx;
        wr.data = '0;
      end
    end else if (fin.opcode == tsl_pkg::OP_ACQUIRE) begin
      if (fin.free) begin
        rsp_next.status     = tsl_pkg::ST_ALLOC;
        rsp_next.slot_index = fin.free_idx[3:0];
        wr.en               = commit;
        wr.idx              = fin.free_idx;
      end else begin
        rsp_next.status = tsl_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
      rsp       <= rsp_next;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Valid bits of every token holder, for the single-transaction check.
  always_comb begin
    live[0] = in_tok.valid;
    for (int k = 1; k <= SLOT_COUNT; k++) begin
      live[k] = chain[k].valid;
    end
    live[SLOT_COUNT+1] = fin.valid;
  end

  // At most one search token is ever in the row.
  assert property (@(posedge clk) disable iff (rst) $countones(live) <= 1)
    else $error("more than one transaction in the cell chain");

  // A finished token exists only while the block is busy.
  assert property (@(posedge clk) disable iff (rst) fin.valid |-> busy)
    else $error("finished token without a busy transaction");

  // The block leaves busy only through a commit.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> $past(commit))
    else $error("busy dropped without a commit");

  // An accepted request launches a token in the next cycle.
  assert property (@(posedge clk) disable iff (rst) req_accept |=> in_tok.valid)
    else $error("accepted request did not launch a token");

endmodule

// ===== verif/texture_slot_table_core_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the slot table core. A short table of directed
// requests runs first, then a long stream of random requests drawn from small
// pools of object ids so that hits, allocations, a full table and releases
// all come up often. Every accepted request transaction goes through a local
// model of the slot store, and every response transaction is checked against
// the oldest prediction still waiting.

module texture_slot_table_core_test;

  localparam int SLOT_COUNT   = 16;
  localparam int RANDOM_ITEMS = 1420;
  // Response back-pressure and the drain pause are injected once each, part
  // way through the random stream.
  localparam int HOLD_AT      = 300;
  localparam int PAUSE_AT     = 750;
  localparam int LONG_HOLD    = 400;
  localparam int POOL_MAX     = 40;
  // Worst case is about 1450 requests, each passing the whole core, plus the
  // longest gaps on both sides; the limit leaves several times that.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_LIMIT  = 5000;

  // One row of the directed table. When known is set the expected response
  // is the one typed into the row; otherwise the local model supplies it.
  typedef struct packed {
    tsl_pkg::op_t      opcode;
    logic [31:0]       object_id;
    logic              known;
    tsl_pkg::status_t  status;
    logic [3:0]        slot;
  } bind_vector_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  tsl_pkg::req_t  req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  tsl_pkg::rsp_t  rsp;

  // Local copy of the slot store, kept in step with accepted requests.
  logic [31:0]    slot_ids [SLOT_COUNT];
  tsl_pkg::rsp_t  pending_rsp_q[$];
  bind_vector_t   vectors[$];
  logic [31:0]    id_pool [POOL_MAX];
  int             pool_size;
  int             err_count   = 0;
  int             cycle_count = 0;
  bit             hold_rsp_now = 1'b0;

  texture_slot_table_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one request to the local store and returns the response the core
  // has to give. The lowest matching slot wins, then the lowest empty one.
  function automatic tsl_pkg::rsp_t resolve_request(tsl_pkg::req_t r);
    tsl_pkg::rsp_t res;
    int            hit_at;
    int            free_at;
    res.status     = tsl_pkg::ST_HIT;
    res.slot_index = '0;
    hit_at         = -1;
    free_at        = -1;
    if (r.opcode == tsl_pkg::OP_CLEAR) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_ids[i] = '0;
      res.status = tsl_pkg::ST_CLEARED;
    end else if (r.object_id == '0) begin
      res.status = tsl_pkg::ST_INVALID;
    end else begin
      // Scanning downward leaves the lowest match and lowest hole behind.
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (slot_ids[i] == r.object_id) hit_at = i;
        if (slot_ids[i] == '0) free_at = i;
      end
      if (hit_at >= 0) begin
        res.slot_index = hit_at[3:0];
        if (r.opcode == tsl_pkg::OP_RELEASE) slot_ids[hit_at] = '0;
      end else if (r.opcode == tsl_pkg::OP_ACQUIRE) begin
        if (free_at >= 0) begin
          slot_ids[free_at] = r.object_id;
          res.slot_index    = free_at[3:0];
          res.status        = tsl_pkg::ST_ALLOC;
        end else begin
          res.status = tsl_pkg::ST_FULL;
        end
      end else begin
        res.status = tsl_pkg::ST_NOTFOUND;
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pool_id();
    return id_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // Mostly acquire, release and lookup on ids of the current pool, with some
  // invalid ids, clears and fully random noise mixed in.
  function automatic tsl_pkg::req_t make_random_request();
    tsl_pkg::req_t item;
    int            r;
    r = $urandom_range(0, 99);
    item.object_id = pool_id();
    if (r < 6) begin
      item.opcode    = tsl_pkg::op_t'($urandom_range(0, 3));
      item.object_id = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    end else if (r < 9) begin
      item.opcode    = ($urandom_range(0, 2) == 0) ? tsl_pkg::OP_ACQUIRE :
                       ($urandom_range(0, 1) == 0) ? tsl_pkg::OP_RELEASE :
                                                     tsl_pkg::OP_LOOKUP;
      item.object_id = '0;
    end else if (r < 11) begin
      item.opcode    = tsl_pkg::OP_CLEAR;
      item.object_id = $urandom;
    end else if (r < 55) begin
      item.opcode = tsl_pkg::OP_ACQUIRE;
    end else if (r < 75) begin
      item.opcode = tsl_pkg::OP_RELEASE;
    end else begin
      item.opcode = tsl_pkg::OP_LOOKUP;
    end
    return item;
  endfunction

  task automatic add_vector(tsl_pkg::op_t op, logic [31:0] id, logic known,
                            tsl_pkg::status_t st, logic [3:0] slot);
    bind_vector_t v;
    v.opcode    = op;
    v.object_id = id;
    v.known     = known;
    v.status    = st;
    v.slot      = slot;
    vectors.push_back(v);
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // Offers one request transaction after an optional idle gap and waits for
  // it to be taken. Valid is only lowered when a gap follows, so back-to-back
  // requests keep it high across the boundary.
  task automatic send_item(tsl_pkg::req_t item, logic known, tsl_pkg::rsp_t known_rsp,
                           int gap);
    tsl_pkg::rsp_t want;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = resolve_request(item);
    if (known) want = known_rsp;
    pending_rsp_q.push_back(want);
  endtask

  // Sender side pause: nothing is offered until every response has come back.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Response checker. Values are read at the edge before any flop of the
  // core updates, which is exactly what the handshake sees.
  always @(posedge clk) begin : rsp_check
    tsl_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp_q.size() == 0) begin
        note_error($sformatf("unexpected response: status %0d slot %0d",
                             rsp.status, rsp.slot_index));
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp.status !== want.status || rsp.slot_index !== want.slot_index) begin
          note_error($sformatf(
            "response mismatch: expected status %0d slot %0d, got status %0d slot %0d",
            want.status, want.slot_index, rsp.status, rsp.slot_index));
        end
      end
    end
  end

  // Receiver side: runs of ready, short and long stalls, and one very long
  // hold-off on request so that the core fills up and stalls its input.
  initial begin : rsp_side
    int r;
    int span;
    forever begin
      if (hold_rsp_now) begin
        hold_rsp_now = 1'b0;
        rsp_ready   <= 1'b0;
        span         = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          rsp_ready <= 1'b1;
          span       = $urandom_range(1, 30);
        end else if (r < 90) begin
          rsp_ready <= 1'b0;
          span       = $urandom_range(1, 3);
        end else begin
          rsp_ready <= 1'b0;
          span       = $urandom_range(4, 40);
        end
      end
      repeat (span) @(posedge clk);
    end
  end

  // Overall watchdog.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    tsl_pkg::req_t  item;
    tsl_pkg::rsp_t  known_rsp;
    int             sent;
    int             ep_len;
    int             waited;
    bit             burst;

    for (int i = 0; i < SLOT_COUNT; i++) slot_ids[i] = '0;

    // Directed table. Misses and invalid ids on the empty table, a clear,
    // first allocations at both id extremes, hits, a release that opens the
    // lowest slot again, then a fill up to the full table.
    add_vector(tsl_pkg::OP_LOOKUP,  32'd5,         1'b1, tsl_pkg::ST_NOTFOUND, 4'd0);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'd0,         1'b1, tsl_pkg::ST_INVALID,  4'd0);
    add_vector(tsl_pkg::OP_RELEASE, 32'd0,         1'b1, tsl_pkg::ST_INVALID,  4'd0);
    add_vector(tsl_pkg::OP_LOOKUP,  32'd0,         1'b1, tsl_pkg::ST_INVALID,  4'd0);
    add_vector(tsl_pkg::OP_CLEAR,   32'h1234_5678, 1'b1, tsl_pkg::ST_CLEARED,  4'd0);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 1'b1, tsl_pkg::ST_ALLOC,    4'd0);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'd1,         1'b1, tsl_pkg::ST_ALLOC,    4'd1);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 1'b1, tsl_pkg::ST_HIT,      4'd0);
    add_vector(tsl_pkg::OP_LOOKUP,  32'd1,         1'b1, tsl_pkg::ST_HIT,      4'd1);
    add_vector(tsl_pkg::OP_RELEASE, 32'hFFFF_FFFF, 1'b1, tsl_pkg::ST_HIT,      4'd0);
    add_vector(tsl_pkg::OP_RELEASE, 32'hFFFF_FFFF, 1'b1, tsl_pkg::ST_NOTFOUND, 4'd0);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'hAAAA_AAAA, 1'b0, tsl_pkg::ST_HIT,      4'd0);
    for (int k = 0; k < SLOT_COUNT - 2; k++)
      add_vector(tsl_pkg::OP_ACQUIRE, 32'h2 << k,  1'b0, tsl_pkg::ST_HIT,      4'd0);
    add_vector(tsl_pkg::OP_ACQUIRE, 32'h5555_5555, 1'b1, tsl_pkg::ST_FULL,     4'd0);
    add_vector(tsl_pkg::OP_CLEAR,   32'd0,         1'b1, tsl_pkg::ST_CLEARED,  4'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) begin
      item.opcode          = vectors[i].opcode;
      item.object_id       = vectors[i].object_id;
      known_rsp.status     = vectors[i].status;
      known_rsp.slot_index = vectors[i].slot;
      send_item(item, vectors[i].known, known_rsp, pick_gap());
    end

    // Random part in episodes. Each episode draws a fresh id pool: small
    // pools give many hits, pools larger than the table drive it full.
    known_rsp = '0;
    sent      = 0;
    while (sent < RANDOM_ITEMS) begin
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(20, POOL_MAX)
                                              : $urandom_range(3, 18);
      for (int k = 0; k < pool_size; k++) begin
        id_pool[k] = $urandom;
        if (id_pool[k] == '0) id_pool[k] = 32'd1;
      end
      if ($urandom_range(0, 3) == 0) id_pool[0] = 32'hFFFF_FFFF;
      burst  = ($urandom_range(0, 4) == 0);
      ep_len = $urandom_range(20, 80);
      for (int n = 0; n < ep_len && sent < RANDOM_ITEMS; n++) begin
        item = make_random_request();
        send_item(item, 1'b0, known_rsp, burst ? 0 : pick_gap());
        sent++;
        if (sent == HOLD_AT) hold_rsp_now = 1'b1;
        if (sent == PAUSE_AT) wait_until_drained();
      end
    end

    // Let the core finish, then give it a few more cycles to show any
    // response it should not produce.
    req_valid <= 1'b0;
    waited = 0;
    while (pending_rsp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      note_error($sformatf("%0d responses never arrived", pending_rsp_q.size()));

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== texture_slot_table_core.f =====
hw/rtl/tsl_pkg.sv
hw/rtl/tsl_cell.sv
hw/rtl/texture_slot_table_core.sv
verif/texture_slot_table_core_test.sv
